// ----- hdl/index_set_merge_with_sign_defines.svh -----
// ---------------------------------------------------------------------------
// index set merge with sign: assertion macros
// shared concurrent check forms, clocked on i_clk, off during reset
// ---------------------------------------------------------------------------
`ifndef INDEX_SET_MERGE_WITH_SIGN_DEFINES_SVH
`define INDEX_SET_MERGE_WITH_SIGN_DEFINES_SVH

// same-cycle implication
`define ISMWS_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ISMWS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/ismws_pkg.sv -----
// ---------------------------------------------------------------------------
// ismws_pkg
// shared types and constants of the index set merge with sign block
// ---------------------------------------------------------------------------
`default_nettype none

package ismws_pkg;

    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DEF_VALUE_BITS  = 8;

    // sign codes, two bit two's complement
    localparam logic signed [1:0] SIGN_ZERO = 2'sb00;
    localparam logic signed [1:0] SIGN_POS  = 2'sb01;
    localparam logic signed [1:0] SIGN_NEG  = 2'sb11;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // insert the input entry
        logic drop;       // store full, flag overflow
        logic shift_out;  // result taken, move the chain down
        logic clear;      // end of run
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic one_left;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- hdl/ismws_ctrl.sv -----
// ---------------------------------------------------------------------------
// ismws_ctrl
// run controller: load entries, then hand out the sorted run
// ---------------------------------------------------------------------------
`default_nettype none

module ismws_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    input  wire                    i_last_entry,
    output logic                   o_stall,
    output logic                   o_valid,
    input  wire                    i_stall,
    input  ismws_pkg::t_dp_status  i_status,
    output ismws_pkg::t_dp_cmd     o_cmd
);
    import ismws_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                if (i_valid) begin
                    o_cmd.load = !i_status.full;
                    o_cmd.drop = i_status.full;
                    if (i_last_entry) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                o_stall = 1'b1;
                o_valid = 1'b1;
                if (!i_stall) begin
                    o_cmd.shift_out = 1'b1;
                    if (i_status.one_left) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_LOAD;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/ismws_dp.sv -----
// ---------------------------------------------------------------------------
// ismws_dp
// insertion chain with parity, duplicate and overflow tracking
// ---------------------------------------------------------------------------
`default_nettype none

module ismws_dp #(
    parameter int MAX_ENTRIES = ismws_pkg::DEF_MAX_ENTRIES,
    parameter int VALUE_BITS  = ismws_pkg::DEF_VALUE_BITS
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  ismws_pkg::t_dp_cmd      i_cmd,
    input  wire [VALUE_BITS-1:0]    i_index_value,
    output ismws_pkg::t_dp_status   o_status,
    output logic [VALUE_BITS-1:0]   o_sorted_value,
    output logic signed [1:0]       o_merge_sign,
    output logic                    o_overflow_flag,
    output logic                    o_last_result
);
    import ismws_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic [VALUE_BITS-1:0] r_cell [MAX_ENTRIES];
    logic [VALUE_BITS-1:0] n_cell [MAX_ENTRIES];
    logic [CNT_W-1:0]      r_count;
    logic                  r_parity;
    logic                  r_dup;
    logic                  r_ovf;

    logic [MAX_ENTRIES-1:0] w_gt;
    logic [MAX_ENTRIES-1:0] w_eq;
    logic [MAX_ENTRIES-1:0] w_ins;

    // compare the new entry against every occupied cell
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_gt[i]  = (CNT_W'(i) < r_count) && (r_cell[i] > i_index_value);
            w_eq[i]  = (CNT_W'(i) < r_count) && (r_cell[i] == i_index_value);
            w_ins[i] = (CNT_W'(i) >= r_count) || w_gt[i];
        end
    end

    // on load, cells at and above the insert point move up by one; on shift_out the chain moves down by one
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            n_cell[i] = r_cell[i];
            if (i_cmd.load) begin
                if (w_ins[i]) begin
                    if (i > 0 && w_ins[(i > 0) ? i - 1 : 0]) begin
                        n_cell[i] = r_cell[(i > 0) ? i - 1 : 0];
                    end else begin
                        n_cell[i] = i_index_value;
                    end
                end
            end else if (i_cmd.shift_out && i < MAX_ENTRIES - 1) begin
                n_cell[i] = r_cell[(i < MAX_ENTRIES - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            r_cell[i] <= n_cell[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_count  <= '0;
            r_parity <= 1'b0;
            r_dup    <= 1'b0;
            r_ovf    <= 1'b0;
        end else if (i_cmd.load) begin
            r_count  <= r_count + CNT_W'(1);
            r_parity <= r_parity ^ (^w_gt);
            r_dup    <= r_dup | (|w_eq);
        end else if (i_cmd.drop) begin
            r_ovf <= 1'b1;
        end else if (i_cmd.shift_out) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    assign o_status.full     = (r_count == CNT_W'(MAX_ENTRIES));
    assign o_status.one_left = (r_count == CNT_W'(1));

    assign o_sorted_value  = r_cell[0];
    assign o_merge_sign    = r_dup ? SIGN_ZERO : (r_parity ? SIGN_NEG : SIGN_POS);
    assign o_overflow_flag = r_ovf;
    assign o_last_result   = (r_count == CNT_W'(1));

endmodule

`default_nettype wire

// ----- hdl/index_set_merge_with_sign.sv -----
// ---------------------------------------------------------------------------
// index_set_merge_with_sign
// merges two index lists into one sorted run and reports the permutation sign
// ---------------------------------------------------------------------------
// input channel: i_valid / o_stall carry one index entry per item, the left
//   list first, then the right list, with i_last_entry set on the final one
// each entry is inserted into a sorted register chain as it is accepted;
//   every occupied cell is compared with it in parallel, so loading never
//   holds an entry back while the one before it is being stored
// after the final entry the block emits the stored entries in ascending
//   order on o_valid / i_stall, one item per cycle while i_stall is low;
//   the first result is valid the cycle after the final entry is accepted
// o_stall is held high while the run is being handed out; no new entry
//   is taken until the last result (o_last_result) has been accepted
// when i_stall is high the current result and the chain simply hold
// entries beyond MAX_ENTRIES are dropped and o_overflow_flag is set
// reset clears the count and the sign and overflow flags; the chain needs
//   no clearing since only occupied cells are ever compared or emitted
// ---------------------------------------------------------------------------
`default_nettype none

module index_set_merge_with_sign #(
    parameter int MAX_ENTRIES = ismws_pkg::DEF_MAX_ENTRIES,
    parameter int VALUE_BITS  = ismws_pkg::DEF_VALUE_BITS
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // entry input
    input  wire                     i_valid,
    output logic                    o_stall,
    input  wire [VALUE_BITS-1:0]    i_index_value,
    input  wire                     i_last_entry,
    // sorted result output
    output logic                    o_valid,
    input  wire                     i_stall,
    output logic [VALUE_BITS-1:0]   o_sorted_value,
    output logic signed [1:0]       o_merge_sign,
    output logic                    o_overflow_flag,
    output logic                    o_last_result
);
    import ismws_pkg::*;

`include "index_set_merge_with_sign_defines.svh"

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencing: load phase, then emit phase
    ismws_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_last_entry (i_last_entry),
        .o_stall      (o_stall),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .i_status     (w_status),
        .o_cmd        (w_cmd)
    );

    // sorted chain and run flags
    ismws_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_index_value   (i_index_value),
        .o_status        (w_status),
        .o_sorted_value  (o_sorted_value),
        .o_merge_sign    (o_merge_sign),
        .o_overflow_flag (o_overflow_flag),
        .o_last_result   (o_last_result)
    );

    // no entry is taken while results are pending
    `ISMWS_ASSERT_NOW(a_stall_in_emit, o_valid, o_stall, "input open during emit")

    // the run ends right after its last result is taken
    `ISMWS_ASSERT_NEXT(a_run_ends, o_valid && !i_stall && o_last_result, !o_valid,
        "results after last")

    // a run never ends early
    `ISMWS_ASSERT_NEXT(a_run_continues, o_valid && !i_stall && !o_last_result, o_valid,
        "run cut short")

    // a final entry always starts an emit phase
    `ISMWS_ASSERT_NEXT(a_emit_starts, i_valid && !o_stall && i_last_entry, o_valid,
        "no results after final entry")

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// index_set_merge_with_sign regression
// self-checking bench: drives runs of index entries, predicts the sorted
// results and their permutation sign, and checks every emitted item
// ---------------------------------------------------------------------------
// the sender offers one entry per item on i_valid / o_stall; the receiver
// takes results on o_valid / i_stall; both sides draw random gaps, with
// stretches of back-to-back traffic and two long receiver hold-offs
// a short directed pass covers the extremes, a single swap, a duplicate and
// a full store whose final entry is dropped; random runs follow, mostly
// strictly ascending left and right lists with random content, the rest
// arbitrary values and runs that overflow the store
// ---------------------------------------------------------------------------

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ismws_pkg::*;

    localparam int MAXE = DEF_MAX_ENTRIES;
    localparam int VB   = DEF_VALUE_BITS;

    localparam int ITEMS_TOTAL    = 470;
    localparam int IDLE_LIMIT     = 1000;   // cycles with no item moving on either side
    localparam int HOLD_CYCLES    = 120;    // long receiver hold-off
    localparam int TAIL_CYCLES    = 2 * MAXE + 8;
    localparam int MAX_MSG_LINES  = 30;

    // one expected result item
    typedef struct {
        logic [VB-1:0]     value;
        logic signed [1:0] sign;
        logic              ovf;
        logic              is_last;
    } t_merge_result;

    // one directed stimulus row: reps entries starting at value, stepping by
    // step; typed rows carry the sign and overflow that the run must end with
    typedef struct {
        int                value;
        int                step;
        int                reps;
        bit                ends_run;
        bit                typed;
        logic signed [1:0] sign;
        bit                ovf;
    } t_stim_row;

    // dut ports
    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_valid       = 1'b0;
    logic              o_stall;
    logic [VB-1:0]     i_index_value = '0;
    logic              i_last_entry  = 1'b0;
    logic              o_valid;
    logic              i_stall       = 1'b0;
    logic [VB-1:0]     o_sorted_value;
    logic signed [1:0] o_merge_sign;
    logic              o_overflow_flag;
    logic              o_last_result;

    // side information that travels with the item on offer
    bit                cur_typed = 1'b0;
    logic signed [1:0] cur_sign  = SIGN_POS;
    bit                cur_ovf   = 1'b0;

    // traffic shaping: no_idle is shared by sender and receiver, hold_request steers the receiver
    bit no_idle      = 1'b0;
    bit hold_request = 1'b0;

    // predictor state: sorted chain, count, parity and flags of the open run
    logic [VB-1:0] sorted_model [MAXE];
    int            model_count   = 0;
    bit            model_parity  = 1'b0;
    bit            model_dup     = 1'b0;
    bit            model_ovf     = 1'b0;

    t_merge_result pending_results[$];
    logic [VB-1:0] run_entries[$];

    int mismatches    = 0;
    int items_sent    = 0;
    int runs_done     = 0;
    int results_seen  = 0;
    int overflow_runs = 0;
    int zero_runs     = 0;
    int odd_runs      = 0;
    int idle_cycles   = 0;

    index_set_merge_with_sign dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_index_value   (i_index_value),
        .i_last_entry    (i_last_entry),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_sorted_value  (o_sorted_value),
        .o_merge_sign    (o_merge_sign),
        .o_overflow_flag (o_overflow_flag),
        .o_last_result   (o_last_result)
    );

    always #6 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_MSG_LINES) begin
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        end
    endtask

    // insertion into the sorted chain; parity gains the count of stored
    // entries above the new one; on the final entry the run is queued
    task automatic absorb_entry(input logic [VB-1:0] v, input logic ends_run,
                                input bit typed, input logic signed [1:0] tsign,
                                input bit tovf);
        int                greater;
        int                pos;
        int                k;
        logic signed [1:0] sgn;
        bit                ovf;
        t_merge_result     r;
        if (model_count >= MAXE) begin
            // store full: entry dropped, no effect on parity or duplicates
            model_ovf = 1'b1;
        end else begin
            greater = 0;
            for (k = 0; k < model_count; k++) begin
                if (sorted_model[k] > v) begin
                    greater++;
                end else if (sorted_model[k] == v) begin
                    model_dup = 1'b1;
                end
            end
            pos = model_count - greater;
            for (k = model_count; k > pos; k--) begin
                sorted_model[k] = sorted_model[k-1];
            end
            sorted_model[pos] = v;
            model_count++;
            model_parity ^= greater[0];
        end
        if (ends_run) begin
            sgn = model_dup ? SIGN_ZERO : (model_parity ? SIGN_NEG : SIGN_POS);
            ovf = model_ovf;
            if (typed) begin
                sgn = tsign;
                ovf = tovf;
            end
            for (k = 0; k < model_count; k++) begin
                r.value   = sorted_model[k];
                r.sign    = sgn;
                r.ovf     = ovf;
                r.is_last = (k == model_count - 1);
                pending_results.insert(pending_results.size(), r);
            end
            runs_done++;
            if (ovf) overflow_runs++;
            if (sgn == SIGN_ZERO) zero_runs++;
            if (sgn == SIGN_NEG) odd_runs++;
            // the run is handed out, everything returns to its cleared state
            model_count  = 0;
            model_parity = 1'b0;
            model_dup    = 1'b0;
            model_ovf    = 1'b0;
        end
    endtask

    // scoreboard: all sampling happens on the pre-edge values
    always @(posedge i_clk) begin
        t_merge_result want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                absorb_entry(i_index_value, i_last_entry, cur_typed, cur_sign, cur_ovf);
            end
            if (o_valid && !i_stall) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    report_mismatch("result item with nothing pending, value",
                                    int'(o_sorted_value), -1);
                end else begin
                    want = pending_results.pop_front();
                    if (o_sorted_value !== want.value)
                        report_mismatch("sorted_value", int'(o_sorted_value),
                                        int'(want.value));
                    if (o_merge_sign !== want.sign)
                        report_mismatch("merge_sign", int'(o_merge_sign), int'(want.sign));
                    if (o_overflow_flag !== want.ovf)
                        report_mismatch("overflow_flag", int'(o_overflow_flag),
                                        int'(want.ovf));
                    if (o_last_result !== want.is_last)
                        report_mismatch("last_result", int'(o_last_result),
                                        int'(want.is_last));
                end
            end
        end
    end

    // watchdog: a stretch with no item moving anywhere ends the run
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
            $display("index_set_merge_with_sign regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random stall before each result, plus the long hold-offs
    initial begin
        int w;
        forever begin
            if (hold_request) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end
            w = no_idle ? 0 : $urandom_range(0, 5);
            if (w > 0) begin
                i_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // sender: one entry per item, random gap before it, held until taken
    task automatic send_entry(input logic [VB-1:0] v, input logic ends_run,
                              input bit typed, input logic signed [1:0] tsign,
                              input bit tovf);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_index_value <= v;
        i_last_entry  <= ends_run;
        cur_typed     <= typed;
        cur_sign      <= tsign;
        cur_ovf       <= tovf;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    // strictly ascending list; wide steps spread it out, narrow steps keep
    // it in a small range so that it collides with the other list
    task automatic add_ascending(input int len);
        int inc;
        int v;
        int k;
        if (len > 0) begin
            if ($urandom_range(0, 2) == 0) begin
                inc = $urandom_range(1, 3);
            end else begin
                inc = (2 ** VB - 1) / len;
                if (inc > 40) inc = 40;
            end
            v = $urandom_range(0, inc - 1);
            for (k = 0; k < len; k++) begin
                run_entries.insert(run_entries.size(), v[VB-1:0]);
                v += $urandom_range(1, inc);
            end
        end
    endtask

    initial begin
        t_stim_row directed_rows [9];
        t_stim_row row;
        int        i;
        int        r;
        int        v;
        int        n;
        int        split;
        int        sel;
        int        run_idx;
        bit        tail_of_row;

        directed_rows = '{
            // single zero straight after reset
            '{'h00,  0,  1, 1'b1, 1'b1, SIGN_POS,  1'b0},
            // single all-ones entry
            '{'hFF,  0,  1, 1'b1, 1'b1, SIGN_POS,  1'b0},
            // left list 9, right list 5: one swap, odd
            '{'h09,  0,  1, 1'b0, 1'b0, SIGN_POS,  1'b0},
            '{'h05,  0,  1, 1'b1, 1'b1, SIGN_NEG,  1'b0},
            // equal entries in the two lists: sign zero
            '{'h07,  0,  1, 1'b0, 1'b0, SIGN_POS,  1'b0},
            '{'h07,  0,  1, 1'b1, 1'b1, SIGN_ZERO, 1'b0},
            // alternating bit patterns, already in order
            '{'h55,  0,  1, 1'b0, 1'b0, SIGN_POS,  1'b0},
            '{'hAA,  0,  1, 1'b1, 1'b0, SIGN_POS,  1'b0},
            // fill the store in descending order: 120 swaps, even
            '{'hF0, -1, MAXE, 1'b0, 1'b0, SIGN_POS, 1'b0}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed pass
        for (i = 0; i < 9; i++) begin
            row = directed_rows[i];
            for (r = 0; r < row.reps; r++) begin
                v = row.value + r * row.step;
                tail_of_row = row.ends_run && (r == row.reps - 1);
                send_entry(v[VB-1:0], tail_of_row, row.typed && tail_of_row,
                           row.sign, row.ovf);
            end
        end
        // final entry arrives with the store full: dropped, and equal to a
        // stored entry, which must not count as a duplicate
        send_entry(8'hF0, 1'b1, 1'b1, SIGN_POS, 1'b1);

        // random runs
        run_idx = 0;
        while (items_sent < ITEMS_TOTAL) begin
            if ($urandom_range(0, 99) < 15) no_idle = !no_idle;
            if (run_idx == 10 || run_idx == 40) hold_request = 1'b1;

            sel = $urandom_range(0, 99);
            if (sel < 75) begin
                n = $urandom_range(1, 8);
            end else if (sel < 92) begin
                n = $urandom_range(9, MAXE);
            end else begin
                n = $urandom_range(MAXE + 1, MAXE + 6);
            end

            run_entries.delete();
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                // well-formed: ascending left list, then ascending right list
                split = $urandom_range(0, n);
                add_ascending(split);
                add_ascending(n - split);
            end else if (sel < 85) begin
                for (r = 0; r < n; r++)
                    run_entries.insert(run_entries.size(),
                                       VB'($urandom_range(0, 2 ** VB - 1)));
            end else begin
                for (r = 0; r < n; r++)
                    run_entries.insert(run_entries.size(), VB'($urandom_range(0, 7)));
            end

            for (r = 0; r < n; r++) begin
                send_entry(run_entries[r], r == n - 1, 1'b0, SIGN_POS, 1'b0);
            end
            run_idx++;
        end
        i_valid <= 1'b0;

        // drain, then a quiet tail to catch stray result items
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d entries in %0d runs, %0d result items checked",
                 items_sent, runs_done, results_seen);
        $display("runs with odd sign %0d, with duplicates %0d, with dropped entries %0d",
                 odd_runs, zero_runs, overflow_runs);
        if (mismatches == 0) begin
            $display("index_set_merge_with_sign regression: pass");
        end else begin
            $display("index_set_merge_with_sign regression: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/ismws_pkg.sv
hdl/ismws_ctrl.sv
hdl/ismws_dp.sv
hdl/index_set_merge_with_sign.sv
tb/testbench.sv
